// ===== rtl/core/htd_pkg.sv =====
package htd_pkg;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_BEGIN = 2'd2,
        ACT_DATA  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        KIND_SYMBOL     = 2'd0,
        KIND_DECODE_ERR = 2'd1,
        KIND_FULL       = 2'd2,
        KIND_ROOT_LEAF  = 2'd3
    } t_kind;

    localparam int SYM_W       = 8;
    localparam int CODE_LEN_W  = 6;
    localparam int CODE_BITS_W = 32;
    localparam int COUNT_IN_W  = 16;
    localparam int BYTE_W      = 8;

    // input tdata layout, lowest field first
    localparam int SYM_LSB       = 0;
    localparam int CODE_LEN_LSB  = SYM_LSB + SYM_W;
    localparam int CODE_BITS_LSB = CODE_LEN_LSB + CODE_LEN_W;
    localparam int COUNT_LSB     = CODE_BITS_LSB + CODE_BITS_W;
    localparam int BYTE_LSB      = COUNT_LSB + COUNT_IN_W;
    localparam int IN_TDATA_W    = 72;

    localparam int OUT_TDATA_W   = 16;

    typedef struct packed {
        t_kind            kind;
        logic [SYM_W-1:0] sym;
        logic             msg_end;
    } t_result;

    typedef struct packed {
        logic    push;
        logic    flush;
        t_result res;
    } t_emit_req;

    typedef struct packed {
        logic go;
        logic flush_done;
    } t_emit_stat;

endpackage

// ===== rtl/core/htd_ram.sv =====
module htd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/htd_emit.sv =====
module htd_emit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  htd_pkg::t_emit_req                  i_req,
    output htd_pkg::t_emit_stat                 o_stat,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [htd_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,  // decoded_symbol, message_end
    output logic [1:0]                          o_m_axis_tuser,  // kind
    output logic                                o_m_axis_tlast
);

    logic             r_o_valid;
    htd_pkg::t_result r_o_res;
    logic             r_o_last;
    logic             r_pend_v;
    htd_pkg::t_result r_pend;
    logic             w_out_free;

    assign w_out_free = !r_o_valid || i_m_axis_tready;

    // the newest result is held back until it is known whether another follows
    assign o_stat.go         = !r_pend_v || w_out_free;
    assign o_stat.flush_done = !r_pend_v || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_pend_v  <= 1'b0;
        end else begin
            if (i_req.push && r_pend_v) begin
                r_o_valid <= 1'b1;
                r_o_res   <= r_pend;
                r_o_last  <= 1'b0;
            end else if (i_req.flush && r_pend_v && w_out_free) begin
                r_o_valid <= 1'b1;
                r_o_res   <= r_pend;
                r_o_last  <= 1'b1;
                r_pend_v  <= 1'b0;
            end else if (i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
            if (i_req.push) begin
                r_pend_v <= 1'b1;
                r_pend   <= i_req.res;
            end
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {{(htd_pkg::OUT_TDATA_W - htd_pkg::SYM_W - 1){1'b0}},
                              r_o_res.msg_end, r_o_res.sym};
    assign o_m_axis_tuser  = r_o_res.kind;
    assign o_m_axis_tlast  = r_o_last;

endmodule

// ===== rtl/core/huffman_tree_decoder_unit.sv =====
// Add code: one tree step per cycle through the node memory, unless the code is
//   skipped.
// Data byte: the walk goes through S_DSTEP and S_DCHILD, one node memory read per
//   tree step, stalls while the output cannot take a result and ends in S_FLUSH.
// Clear, begin message and idle data: handled in S_IDLE, plus S_FLUSH for a result.
// Reset (i_rst_n low, synchronous) clears control state, then S_INIT writes
//   the root entry before the first item is taken.
module huffman_tree_decoder_unit #(
    parameter int SYMBOL_COUNT  = 256,
    parameter int NODE_COUNT    = 512,
    parameter int MAX_CODE_BITS = 32,
    parameter int COUNT_BITS    = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // symbol, code_length, code_bits, symbol_count, data_byte
    input  logic [htd_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    input  logic [1:0]                          i_s_axis_tuser,   // action
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [htd_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,   // decoded_symbol, message_end
    output logic [1:0]                          o_m_axis_tuser,   // kind
    output logic                                o_m_axis_tlast
);

    localparam int NW = $clog2(NODE_COUNT);
    localparam int FW = $clog2(NODE_COUNT + 1);
    localparam int EW = 2 * NW + htd_pkg::SYM_W;

    typedef struct packed {
        logic [NW-1:0]            left;
        logic [NW-1:0]            right;
        logic [htd_pkg::SYM_W-1:0] sym;
    } t_node;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_ADD,
        S_DSTEP,
        S_DCHILD,
        S_FLUSH
    } t_state;

    function automatic logic [1:0] f_shape(t_node n);
        f_shape = {1'b0, n.left != '0} + {1'b0, n.right != '0};
    endfunction

    t_state                           r_state, n_state;
    logic [FW-1:0]                    r_free, n_free;
    logic [NW-1:0]                    r_walk, n_walk;
    logic [COUNT_BITS-1:0]            r_left, n_left;
    logic                             r_active, n_active;
    t_node                            r_root, n_root;
    t_node                            r_cur, n_cur;
    logic                             r_cur_ram, n_cur_ram;
    logic [NW-1:0]                    r_cur_addr, n_cur_addr;
    logic [htd_pkg::CODE_LEN_W-1:0]   r_j, n_j;
    logic [htd_pkg::CODE_LEN_W-1:0]   r_len, n_len;
    logic [htd_pkg::CODE_BITS_W-1:0]  r_bits, n_bits;
    logic [htd_pkg::SYM_W-1:0]        r_sym, n_sym;
    logic [htd_pkg::BYTE_W-1:0]       r_byte, n_byte;
    logic [2:0]                       r_bit, n_bit;

    logic                             mem_we;
    logic [NW-1:0]                    mem_waddr;
    t_node                            mem_wdata;
    logic                             mem_re;
    logic [NW-1:0]                    mem_raddr;
    logic [EW-1:0]                    mem_rdata;
    t_node                            w_rnode;
    t_node                            w_cur;

    htd_pkg::t_emit_req               w_req;
    htd_pkg::t_emit_stat              w_stat;

    htd_pkg::t_action                 w_act;
    logic [htd_pkg::SYM_W-1:0]        w_in_sym;
    logic [htd_pkg::CODE_LEN_W-1:0]   w_in_len;
    logic [htd_pkg::CODE_LEN_W-1:0]   w_eff_len;
    logic [htd_pkg::CODE_BITS_W-1:0]  w_in_bits;
    logic [COUNT_BITS-1:0]            w_in_count;
    logic [htd_pkg::BYTE_W-1:0]       w_in_byte;
    logic                             w_sym_ok;
    logic                             w_accept;

    logic                             w_code_bit;
    logic [NW-1:0]                    w_slot;
    logic [NW-1:0]                    w_child;
    logic [NW-1:0]                    w_grand;
    logic [1:0]                       w_cur_shape;
    logic [1:0]                       w_rnode_shape;

    assign w_act      = htd_pkg::t_action'(i_s_axis_tuser);
    assign w_in_sym   = i_s_axis_tdata[htd_pkg::SYM_LSB +: htd_pkg::SYM_W];
    assign w_in_len   = i_s_axis_tdata[htd_pkg::CODE_LEN_LSB +: htd_pkg::CODE_LEN_W];
    assign w_in_bits  = i_s_axis_tdata[htd_pkg::CODE_BITS_LSB +: htd_pkg::CODE_BITS_W];
    assign w_in_count = COUNT_BITS'(i_s_axis_tdata[htd_pkg::COUNT_LSB +: htd_pkg::COUNT_IN_W]);
    assign w_in_byte  = i_s_axis_tdata[htd_pkg::BYTE_LSB +: htd_pkg::BYTE_W];
    assign w_sym_ok   = {1'b0, w_in_sym} < 9'(SYMBOL_COUNT);
    assign w_eff_len  = (32'(w_in_len) > MAX_CODE_BITS) ?
                        htd_pkg::CODE_LEN_W'(MAX_CODE_BITS) : w_in_len;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_rnode       = t_node'(mem_rdata);
    assign w_cur         = r_cur_ram ? w_rnode : r_cur;
    assign w_cur_shape   = f_shape(w_cur);
    assign w_rnode_shape = f_shape(w_rnode);
    assign w_code_bit    = (r_j < 6'd32) ? r_bits[r_j[4:0]] : 1'b0;
    assign w_slot        = w_code_bit ? w_cur.right : w_cur.left;
    assign w_child       = r_byte[r_bit] ? w_cur.right : w_cur.left;
    assign w_grand       = r_byte[3'(r_bit + 3'd1)] ? w_rnode.right : w_rnode.left;

    always_comb begin
        n_state    = r_state;
        n_free     = r_free;
        n_walk     = r_walk;
        n_left     = r_left;
        n_active   = r_active;
        n_root     = r_root;
        n_cur      = r_cur;
        n_cur_ram  = r_cur_ram;
        n_cur_addr = r_cur_addr;
        n_j        = r_j;
        n_len      = r_len;
        n_bits     = r_bits;
        n_sym      = r_sym;
        n_byte     = r_byte;
        n_bit      = r_bit;
        mem_we     = 1'b0;
        mem_waddr  = r_cur_addr;
        mem_wdata  = w_cur;
        mem_re     = 1'b0;
        mem_raddr  = r_cur_addr;
        w_req      = '0;

        case (r_state)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = '0;
                n_state   = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) begin
                    case (w_act)
                        htd_pkg::ACT_CLEAR: begin
                            mem_we    = 1'b1;
                            mem_waddr = '0;
                            mem_wdata = '0;
                            n_free    = FW'(1);
                            n_walk    = '0;
                            n_left    = '0;
                            n_active  = 1'b0;
                        end
                        htd_pkg::ACT_ADD: begin
                            if (w_in_len != '0 && w_sym_ok) begin
                                n_cur      = r_root;
                                n_cur_ram  = 1'b0;
                                n_cur_addr = '0;
                                n_j        = '0;
                                n_len      = w_eff_len;
                                n_bits     = w_in_bits;
                                n_sym      = w_in_sym;
                                n_state    = S_ADD;
                            end
                        end
                        htd_pkg::ACT_BEGIN: begin
                            n_active = 1'b0;
                            n_left   = '0;
                            n_walk   = '0;
                            if (w_in_count != '0) begin
                                if (f_shape(r_root) == 2'd0) begin
                                    w_req.push         = 1'b1;
                                    w_req.res.kind     = htd_pkg::KIND_ROOT_LEAF;
                                    w_req.res.msg_end  = 1'b1;
                                    n_state            = S_FLUSH;
                                end else if (f_shape(r_root) == 2'd1) begin
                                    w_req.push         = 1'b1;
                                    w_req.res.kind     = htd_pkg::KIND_DECODE_ERR;
                                    w_req.res.msg_end  = 1'b1;
                                    n_state            = S_FLUSH;
                                end else begin
                                    n_left   = w_in_count;
                                    n_active = 1'b1;
                                end
                            end
                        end
                        htd_pkg::ACT_DATA: begin
                            if (r_active) begin
                                mem_re    = 1'b1;
                                mem_raddr = r_walk;
                                n_cur_ram = 1'b1;
                                n_bit     = '0;
                                n_byte    = w_in_byte;
                                n_state   = S_DSTEP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ADD: begin
                if (r_j == r_len) begin
                    mem_we        = 1'b1;
                    mem_wdata.sym = r_sym;
                    n_state       = S_IDLE;
                end else if (w_slot != '0) begin
                    mem_re     = 1'b1;
                    mem_raddr  = w_slot;
                    n_cur_addr = w_slot;
                    n_cur_ram  = 1'b1;
                    n_j        = r_j + 6'd1;
                end else if (r_free == FW'(NODE_COUNT)) begin
                    // keep nodes made so far; the current node is written back unchanged
                    mem_we            = 1'b1;
                    w_req.push        = 1'b1;
                    w_req.res.kind    = htd_pkg::KIND_FULL;
                    w_req.res.msg_end = 1'b1;
                    n_state           = S_FLUSH;
                end else begin
                    mem_we = 1'b1;
                    if (w_code_bit) begin
                        mem_wdata.right = r_free[NW-1:0];
                    end else begin
                        mem_wdata.left  = r_free[NW-1:0];
                    end
                    n_cur      = '0;
                    n_cur_ram  = 1'b0;
                    n_cur_addr = r_free[NW-1:0];
                    n_free     = r_free + FW'(1);
                    n_j        = r_j + 6'd1;
                end
            end
            S_DSTEP: begin
                if (w_stat.go) begin
                    if (w_cur_shape != 2'd2) begin
                        w_req.push        = 1'b1;
                        w_req.res.kind    = (w_cur_shape == 2'd0 && r_walk == '0) ?
                                            htd_pkg::KIND_ROOT_LEAF :
                                            htd_pkg::KIND_DECODE_ERR;
                        w_req.res.msg_end = 1'b1;
                        n_active          = 1'b0;
                        n_left            = '0;
                        n_walk            = '0;
                        n_state           = S_FLUSH;
                    end else begin
                        mem_re     = 1'b1;
                        mem_raddr  = w_child;
                        n_cur_addr = w_child;
                        n_state    = S_DCHILD;
                    end
                end
            end
            S_DCHILD: begin
                if (w_stat.go) begin
                    if (w_rnode_shape == 2'd0) begin
                        w_req.push    = 1'b1;
                        w_req.res.kind = htd_pkg::KIND_SYMBOL;
                        w_req.res.sym = w_rnode.sym;
                        n_walk        = '0;
                        n_left        = r_left - COUNT_BITS'(1);
                        if (r_left == COUNT_BITS'(1)) begin
                            // discard the rest of the byte
                            w_req.res.msg_end = 1'b1;
                            n_active          = 1'b0;
                            n_state           = S_FLUSH;
                        end else if (r_bit == 3'd7) begin
                            n_state = S_FLUSH;
                        end else begin
                            n_bit     = r_bit + 3'd1;
                            n_cur     = r_root;
                            n_cur_ram = 1'b0;
                            n_state   = S_DSTEP;
                        end
                    end else if (w_rnode_shape == 2'd1) begin
                        w_req.push        = 1'b1;
                        w_req.res.kind    = htd_pkg::KIND_DECODE_ERR;
                        w_req.res.msg_end = 1'b1;
                        n_active          = 1'b0;
                        n_left            = '0;
                        n_walk            = '0;
                        n_state           = S_FLUSH;
                    end else begin
                        n_walk = r_cur_addr;
                        if (r_bit == 3'd7) begin
                            n_state = S_FLUSH;
                        end else begin
                            // internal node: step straight on to its child
                            mem_re     = 1'b1;
                            mem_raddr  = w_grand;
                            n_cur_addr = w_grand;
                            n_bit      = r_bit + 3'd1;
                        end
                    end
                end
            end
            S_FLUSH: begin
                w_req.flush = 1'b1;
                if (w_stat.flush_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // mirror the root entry in a register
        if (mem_we && mem_waddr == '0) begin
            n_root = mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_free    <= FW'(1);
            r_walk    <= '0;
            r_left    <= '0;
            r_active  <= 1'b0;
            r_root    <= '0;
            r_cur_ram <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_free    <= n_free;
            r_walk    <= n_walk;
            r_left    <= n_left;
            r_active  <= n_active;
            r_root    <= n_root;
            r_cur_ram <= n_cur_ram;
        end
        r_cur      <= n_cur;
        r_cur_addr <= n_cur_addr;
        r_j        <= n_j;
        r_len      <= n_len;
        r_bits     <= n_bits;
        r_sym      <= n_sym;
        r_byte     <= n_byte;
        r_bit      <= n_bit;
    end

    htd_ram #(
        .WIDTH (EW),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (EW'(mem_wdata)),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    htd_emit u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (w_req),
        .o_stat          (w_stat),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= FW'(NODE_COUNT) && r_free != '0)
        else $error("free node pointer out of range");

    a_walk_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_walk} < (NW + 1)'(r_free))
        else $error("walk points past allocated nodes");

    a_active_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> r_left != '0)
        else $error("active message with no symbols left");

    a_error_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != 2'(htd_pkg::KIND_SYMBOL)
            |-> o_m_axis_tdata[htd_pkg::SYM_W] && o_m_axis_tlast)
        else $error("error result does not end the message");

endmodule
